FILE: rtl/tcvd_pkg.sv
// ----------------------------------------------------------------------------
// Toroidal cutter vertex drop: shared package
// Types, stage numbering and register indexes used across the block.
// ----------------------------------------------------------------------------
package tcvd_pkg;

    localparam int NUM_VTX      = 3;
    localparam int SQRT_BITS    = 4;
    localparam int ROOT_W       = 32;
    localparam int SQRT_STAGES  = ROOT_W / SQRT_BITS;

    localparam int ST_DIFF      = 0;
    localparam int ST_SQ        = 1;
    localparam int ST_SUM       = 2;
    localparam int ST_REGION    = 3;
    localparam int ST_SQRT1     = 4;
    localparam int ST_T         = ST_SQRT1 + SQRT_STAGES;
    localparam int ST_TSQ       = ST_T + 1;
    localparam int ST_INNER     = ST_TSQ + 1;
    localparam int ST_SQRT2     = ST_INNER + 1;
    localparam int ST_H1        = ST_SQRT2 + SQRT_STAGES;
    localparam int ST_TIP       = ST_H1 + 1;
    localparam int ST_PICK      = ST_TIP + 1;
    localparam int NUM_STAGES   = ST_PICK + 1;

    typedef enum logic [1:0] {
        CFG_FLAT_RADIUS   = 2'd0,
        CFG_CORNER_RADIUS = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        ax;
        logic [31:0]        ay;
        logic [63:0]        sx;
        logic [63:0]        sy;
        logic [63:0]        d2;
        logic               flat;
        logic               corner;
        logic [63:0]        rem;
        logic [31:0]        root;
        logic [30:0]        t;
        logic [61:0]        tsq;
        logic [30:0]        h1;
        logic signed [32:0] tip;
    } lane_t;

    typedef struct packed {
        lane_t [NUM_VTX-1:0] lane;
        logic signed [31:0]  loc_x;
        logic signed [31:0]  loc_y;
        logic signed [31:0]  loc_z;
        logic signed [31:0]  new_z;
        logic signed [31:0]  cx;
        logic signed [31:0]  cy;
        logic signed [31:0]  cz;
        logic                lifted;
    } item_t;

endpackage

FILE: rtl/tcvd_if.sv
// ----------------------------------------------------------------------------
// Toroidal cutter vertex drop: channel interfaces
// Query and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcvd_query_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] loc_x;
    logic signed [31:0] loc_y;
    logic signed [31:0] loc_z;
    logic signed [31:0] va_x;
    logic signed [31:0] va_y;
    logic signed [31:0] va_z;
    logic signed [31:0] vb_x;
    logic signed [31:0] vb_y;
    logic signed [31:0] vb_z;
    logic signed [31:0] vc_x;
    logic signed [31:0] vc_y;
    logic signed [31:0] vc_z;

    modport source (output valid, loc_x, loc_y, loc_z, va_x, va_y, va_z,
                    vb_x, vb_y, vb_z, vc_x, vc_y, vc_z, input ready);
    modport sink   (input valid, loc_x, loc_y, loc_z, va_x, va_y, va_z,
                    vb_x, vb_y, vb_z, vc_x, vc_y, vc_z, output ready);
endinterface

interface tcvd_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_loc_z;
    logic signed [31:0] contact_x;
    logic signed [31:0] contact_y;
    logic signed [31:0] contact_z;
    logic               lifted;

    modport source (output valid, new_loc_z, contact_x, contact_y, contact_z,
                    lifted, input ready);
    modport sink   (input valid, new_loc_z, contact_x, contact_y, contact_z,
                    lifted, output ready);
endinterface

FILE: rtl/tcvd_sqrt_stage.sv
// ----------------------------------------------------------------------------
// Toroidal cutter vertex drop: square root slice
// Resolves a few root bits of a restoring integer square root.
// ----------------------------------------------------------------------------
module tcvd_sqrt_stage
    import tcvd_pkg::*;
#(
    parameter int HI_BIT = 31
)
(
    input  logic [63:0] rem_in,
    input  logic [31:0] root_in,
    output logic [63:0] rem_out,
    output logic [31:0] root_out
);

    always_comb
    begin
        logic [65:0] rem;
        logic [31:0] root;
        logic [65:0] trial;
        int          b;
        rem  = {2'b00, rem_in};
        root = root_in;
        for (int i = 0; i < SQRT_BITS; i++)
        begin
            b     = HI_BIT - i;
            trial = ({34'd0, root} << (b + 1)) + (66'd1 << (2 * b));
            if (rem >= trial)
            begin
                rem     = rem - trial;
                root[b] = 1'b1;
            end
        end
        rem_out  = rem[63:0];
        root_out = root;
    end

endmodule

FILE: rtl/toroidal_cutter_vertex_drop.sv
// ----------------------------------------------------------------------------
// Toroidal cutter vertex drop
// Drops a bull-nose cutter onto the three vertices of one triangle.
// ----------------------------------------------------------------------------
// The block takes one query word per clock cycle while the result channel is
// not held, and returns one result word for each.
// Each of the two pipelined square roots resolves four root bits per stage
// over eight stages, and all three vertices are worked in parallel lanes. A held
// result stalls only the unbroken run of full stages directly behind it, so
// empty stages keep filling and new queries are taken while the first stage
// can advance. Radius writes must be made while no query is in flight.
module toroidal_cutter_vertex_drop
    import tcvd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_en,
    input  logic [1:0]    cfg_index,
    input  logic [30:0]   cfg_data,
    tcvd_query_if.sink    query,
    tcvd_result_if.source result
);

    logic [30:0] r1_reg;
    logic [30:0] r2_reg;
    logic [61:0] r1sq_reg;
    logic [61:0] r2sq_reg;
    logic [63:0] rsumsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_reg <= 31'd19661;
            r2_reg <= 31'd13107;
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                CFG_FLAT_RADIUS:   r1_reg <= cfg_data;
                CFG_CORNER_RADIUS: r2_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        logic [31:0] rsum;
        rsum       = {1'b0, r1_reg} + {1'b0, r2_reg};
        r1sq_reg   <= r1_reg * r1_reg;
        r2sq_reg   <= r2_reg * r2_reg;
        rsumsq_reg <= rsum * rsum;
    end

    item_t                  pipe_reg [NUM_STAGES];
    item_t                  pipe_next[NUM_STAGES];
    logic [NUM_STAGES-1:0]  valid_reg;
    logic [NUM_STAGES-1:0]  adv;

    logic [63:0] sq_rem [NUM_STAGES][NUM_VTX];
    logic [31:0] sq_root[NUM_STAGES][NUM_VTX];

    for (genvar k = 0; k < NUM_STAGES; k++)
    begin : g_stage
        for (genvar l = 0; l < NUM_VTX; l++)
        begin : g_lane
            if ((k >= ST_SQRT1 && k < ST_T) || (k >= ST_SQRT2 && k < ST_H1))
            begin : g_sqrt
                localparam int J = (k >= ST_SQRT2) ? k - ST_SQRT2 : k - ST_SQRT1;
                tcvd_sqrt_stage #(.HI_BIT(ROOT_W - 1 - J * SQRT_BITS)) u_sqrt (
                    .rem_in   (pipe_reg[k-1].lane[l].rem),
                    .root_in  (pipe_reg[k-1].lane[l].root),
                    .rem_out  (sq_rem[k][l]),
                    .root_out (sq_root[k][l])
                );
            end
            else
            begin : g_none
                assign sq_rem[k][l]  = 64'd0;
                assign sq_root[k][l] = 32'd0;
            end
        end
    end

    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || result.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign query.ready = adv[0];

    always_comb
    begin
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [64:0]        sum;
        logic [31:0]        tq;
        logic signed [32:0] cur;
        item_t              it;
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            if (k == ST_DIFF)
            begin
                it       = '0;
                it.loc_x = query.loc_x;
                it.loc_y = query.loc_y;
                it.loc_z = query.loc_z;
                it.lane[0].x = query.va_x;
                it.lane[0].y = query.va_y;
                it.lane[0].z = query.va_z;
                it.lane[1].x = query.vb_x;
                it.lane[1].y = query.vb_y;
                it.lane[1].z = query.vb_z;
                it.lane[2].x = query.vc_x;
                it.lane[2].y = query.vc_y;
                it.lane[2].z = query.vc_z;
            end
            else
            begin
                it = pipe_reg[k-1];
            end
            for (int l = 0; l < NUM_VTX; l++)
            begin
                if (k == ST_DIFF)
                begin
                    dx = {it.loc_x[31], it.loc_x} - {it.lane[l].x[31], it.lane[l].x};
                    dy = {it.loc_y[31], it.loc_y} - {it.lane[l].y[31], it.lane[l].y};
                    it.lane[l].ax = dx[32] ? 32'(-dx) : dx[31:0];
                    it.lane[l].ay = dy[32] ? 32'(-dy) : dy[31:0];
                end
                else if (k == ST_SQ)
                begin
                    it.lane[l].sx = it.lane[l].ax * it.lane[l].ax;
                    it.lane[l].sy = it.lane[l].ay * it.lane[l].ay;
                end
                else if (k == ST_SUM)
                begin
                    sum = {1'b0, it.lane[l].sx} + {1'b0, it.lane[l].sy};
                    it.lane[l].d2 = sum[64] ? {64{1'b1}} : sum[63:0];
                end
                else if (k == ST_REGION)
                begin
                    it.lane[l].flat   = it.lane[l].d2 <= {2'b00, r1sq_reg};
                    it.lane[l].corner = !it.lane[l].flat && it.lane[l].d2 <= rsumsq_reg;
                    it.lane[l].rem    = it.lane[l].d2;
                    it.lane[l].root   = '0;
                end
                else if ((k >= ST_SQRT1 && k < ST_T) || (k >= ST_SQRT2 && k < ST_H1))
                begin
                    it.lane[l].rem  = sq_rem[k][l];
                    it.lane[l].root = sq_root[k][l];
                end
                else if (k == ST_T)
                begin
                    tq = it.lane[l].root;
                    if (tq <= {1'b0, r1_reg})
                        it.lane[l].t = '0;
                    else if (tq - {1'b0, r1_reg} > {1'b0, r2_reg})
                        it.lane[l].t = r2_reg;
                    else
                        it.lane[l].t = 31'(tq - {1'b0, r1_reg});
                end
                else if (k == ST_TSQ)
                begin
                    it.lane[l].tsq = it.lane[l].t * it.lane[l].t;
                end
                else if (k == ST_INNER)
                begin
                    it.lane[l].rem  = {2'b00, r2sq_reg - it.lane[l].tsq};
                    it.lane[l].root = '0;
                end
                else if (k == ST_H1)
                begin
                    it.lane[l].h1 = r2_reg - it.lane[l].root[30:0];
                end
                else if (k == ST_TIP)
                begin
                    it.lane[l].tip = it.lane[l].corner
                        ? ({it.lane[l].z[31], it.lane[l].z} - $signed({2'b00, it.lane[l].h1}))
                        : {it.lane[l].z[31], it.lane[l].z};
                end
            end
            if (k == ST_PICK)
            begin
                cur       = {it.loc_z[31], it.loc_z};
                it.cx     = '0;
                it.cy     = '0;
                it.cz     = '0;
                it.lifted = 1'b0;
                for (int l = 0; l < NUM_VTX; l++)
                begin
                    if ((it.lane[l].flat || it.lane[l].corner) && it.lane[l].tip > cur)
                    begin
                        cur       = it.lane[l].tip;
                        it.cx     = it.lane[l].x;
                        it.cy     = it.lane[l].y;
                        it.cz     = it.lane[l].z;
                        it.lifted = 1'b1;
                    end
                end
                it.new_z = cur[31:0];
            end
            pipe_next[k] = it;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
                valid_reg[0] <= query.valid;
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (adv[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            if (adv[k])
                pipe_reg[k] <= pipe_next[k];
        end
    end

    assign result.valid     = valid_reg[NUM_STAGES-1];
    assign result.new_loc_z = pipe_reg[NUM_STAGES-1].new_z;
    assign result.contact_x = pipe_reg[NUM_STAGES-1].cx;
    assign result.contact_y = pipe_reg[NUM_STAGES-1].cy;
    assign result.contact_z = pipe_reg[NUM_STAGES-1].cz;
    assign result.lifted    = pipe_reg[NUM_STAGES-1].lifted;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        query.valid && query.ready |=> valid_reg[0])
        else $error("Accepted query word did not enter the pipeline.");

    a_no_lift_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.lifted |->
            result.contact_x == 0 && result.contact_y == 0 && result.contact_z == 0)
        else $error("Contact point set without a lift.");

    a_no_lift_height: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.lifted |->
            result.new_loc_z == pipe_reg[NUM_STAGES-1].loc_z)
        else $error("Tip height changed without a lift.");

    a_lift_raises: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.lifted |->
            result.new_loc_z > pipe_reg[NUM_STAGES-1].loc_z)
        else $error("Lift did not raise the tip height.");

endmodule
